FILE: hdl/lruc_pkg.sv
// Package for the LRU tag cache: sizes, mode codes and the request structs
// shared by the tag store, the recency store and the top level. No dependencies.
`default_nettype none

package lruc_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int KEY_W      = 16;
    localparam int MODE_W     = 2;
    localparam int SLOT_OUT_W = 4;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FILL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INVAL  = 2'd2;

    localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(SLOTS - 1);

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [KEY_W-1:0]  key_t;

    typedef struct packed {
        logic  rd;
        slot_t raddr;
        logic  wr;
        slot_t waddr;
        key_t  wdata;
        logic  clear;
    } tag_req_t;

    typedef struct packed {
        logic  rd;
        slot_t raddr;
        logic  wr;
        slot_t waddr;
        slot_t wdata;
        logic  clear;
    } ord_req_t;

    // low bits of a slot number as carried on the result port
    function automatic logic [SLOT_OUT_W-1:0] slot_out(input slot_t s);
        logic [SLOT_W+SLOT_OUT_W-1:0] e;
        e = {{SLOT_OUT_W{1'b0}}, s};
        return e[SLOT_OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/lruc_tag_store.sv
// Tag store: one key tag per slot in a synchronous memory with a registered read.
// Per-entry valid bits make unwritten entries read as zero. Uses lruc_pkg.
`default_nettype none

module lruc_tag_store (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lruc_pkg::tag_req_t req,
    output logic [lruc_pkg::KEY_W-1:0] q
);

    logic [lruc_pkg::KEY_W-1:0] mem [lruc_pkg::SLOTS];
    logic [lruc_pkg::KEY_W-1:0] mem_q_reg;
    logic [lruc_pkg::SLOTS-1:0] valid_reg;
    logic                       q_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.rd)
        begin
            mem_q_reg <= mem[req.raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.rd)
            begin
                q_valid_reg <= valid_reg[req.raddr];
            end
        end
    end

    assign q = q_valid_reg ? mem_q_reg : '0;

endmodule

`default_nettype wire

FILE: hdl/lruc_order_store.sv
// Recency store: slot number per recency position, synchronous memory with
// a registered read. Unwritten positions read as their own index. Uses lruc_pkg.
`default_nettype none

module lruc_order_store (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lruc_pkg::ord_req_t req,
    output lruc_pkg::slot_t        q
);

    lruc_pkg::slot_t            mem [lruc_pkg::SLOTS];
    lruc_pkg::slot_t            mem_q_reg;
    lruc_pkg::slot_t            addr_q_reg;
    logic [lruc_pkg::SLOTS-1:0] valid_reg;
    logic                       q_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.rd)
        begin
            mem_q_reg  <= mem[req.raddr];
            addr_q_reg <= req.raddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.rd)
            begin
                q_valid_reg <= valid_reg[req.raddr];
            end
        end
    end

    assign q = q_valid_reg ? mem_q_reg : addr_q_reg;

endmodule

`default_nettype wire

FILE: hdl/lru_tag_cache_16_slot_top.sv
// Top level of the LRU tag cache: sequencer over the tag and recency stores.
// Depends on lruc_pkg, lruc_tag_store and lruc_order_store.
`default_nettype none

// One beat at a time. A lookup scans the tags one slot per cycle until the
// first match; a hit then walks the recency list from the front, shifting it
// one position per cycle until the hit slot is reached. A miss, and a lookup
// of key zero without any scan, reports the least recent slot from the end
// of the recency list. A fill writes the key into that least recent slot and
// then walks the recency list in the same way to bring it to the front. An
// invalidate or an unused mode goes straight to the result. The single read
// port of each store paces the scan and the walk. The result beat is held
// until taken; the next input beat is accepted after it.
module lru_tag_cache_16_slot_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [lruc_pkg::MODE_W-1:0]      mode,
    input  wire logic [lruc_pkg::KEY_W-1:0]       key,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  hit,
    output logic [lruc_pkg::SLOT_OUT_W-1:0]       slot
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TSCAN,
        ST_VREAD,
        ST_PROMOTE,
        ST_RESP
    } state_t;

    state_t                          state_reg, state_next;
    logic [lruc_pkg::MODE_W-1:0]     mode_reg, mode_next;
    lruc_pkg::key_t                  key_reg, key_next;
    lruc_pkg::slot_t                 idx_reg, idx_next;
    lruc_pkg::slot_t                 carry_reg, carry_next;
    lruc_pkg::slot_t                 tgt_reg, tgt_next;
    logic                            hit_reg, hit_next;
    logic [lruc_pkg::SLOT_OUT_W-1:0] slot_reg, slot_next;

    lruc_pkg::tag_req_t tag_req;
    lruc_pkg::ord_req_t ord_req;
    lruc_pkg::key_t     tag_q;
    lruc_pkg::slot_t    ord_q;
    lruc_pkg::slot_t    idx_inc;
    logic               accept;

    lruc_tag_store u_tag (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (tag_req),
        .q    (tag_q)
    );

    lruc_order_store u_order (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (ord_req),
        .q    (ord_q)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_RESP);
    assign hit       = hit_reg;
    assign slot      = slot_reg;
    assign accept    = in_valid && in_ready;
    assign idx_inc   = (idx_reg == lruc_pkg::LAST_POS) ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        carry_next = carry_reg;
        tgt_next   = tgt_reg;
        hit_next   = hit_reg;
        slot_next  = slot_reg;
        tag_req    = '0;
        ord_req    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = mode;
                    key_next  = key;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    slot_next = '0;
                    if (mode == lruc_pkg::MODE_LOOKUP && key != '0)
                    begin
                        tag_req.rd    = 1'b1;
                        tag_req.raddr = '0;
                        state_next    = ST_TSCAN;
                    end
                    else if (mode == lruc_pkg::MODE_LOOKUP || mode == lruc_pkg::MODE_FILL)
                    begin
                        ord_req.rd    = 1'b1;
                        ord_req.raddr = lruc_pkg::LAST_POS;
                        state_next    = ST_VREAD;
                    end
                    else
                    begin
                        if (mode == lruc_pkg::MODE_INVAL)
                        begin
                            tag_req.clear = 1'b1;
                            ord_req.clear = 1'b1;
                        end
                        state_next = ST_RESP;
                    end
                end
            end

            ST_TSCAN:
            begin
                // tag_q belongs to slot idx_reg
                if (tag_q == key_reg)
                begin
                    hit_next      = 1'b1;
                    slot_next     = lruc_pkg::slot_out(idx_reg);
                    tgt_next      = idx_reg;
                    carry_next    = idx_reg;
                    idx_next      = '0;
                    ord_req.rd    = 1'b1;
                    ord_req.raddr = '0;
                    state_next    = ST_PROMOTE;
                end
                else if (idx_reg == lruc_pkg::LAST_POS)
                begin
                    ord_req.rd    = 1'b1;
                    ord_req.raddr = lruc_pkg::LAST_POS;
                    state_next    = ST_VREAD;
                end
                else
                begin
                    tag_req.rd    = 1'b1;
                    tag_req.raddr = idx_inc;
                    idx_next      = idx_inc;
                end
            end

            ST_VREAD:
            begin
                // ord_q is the least recent slot
                slot_next = lruc_pkg::slot_out(ord_q);
                if (mode_reg == lruc_pkg::MODE_FILL)
                begin
                    tag_req.wr    = 1'b1;
                    tag_req.waddr = ord_q;
                    tag_req.wdata = key_reg;
                    tgt_next      = ord_q;
                    carry_next    = ord_q;
                    idx_next      = '0;
                    ord_req.rd    = 1'b1;
                    ord_req.raddr = '0;
                    state_next    = ST_PROMOTE;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end

            ST_PROMOTE:
            begin
                // shift list down by one until the promoted slot's old position
                ord_req.wr    = 1'b1;
                ord_req.waddr = idx_reg;
                ord_req.wdata = carry_reg;
                carry_next    = ord_q;
                if (ord_q == tgt_reg || idx_reg == lruc_pkg::LAST_POS)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    ord_req.rd    = 1'b1;
                    ord_req.raddr = idx_inc;
                    idx_next      = idx_inc;
                end
            end

            ST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= '0;
            key_reg   <= '0;
            idx_reg   <= '0;
            carry_reg <= '0;
            tgt_reg   <= '0;
            hit_reg   <= 1'b0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            key_reg   <= key_next;
            idx_reg   <= idx_next;
            carry_reg <= carry_next;
            tgt_reg   <= tgt_next;
            hit_reg   <= hit_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

`default_nettype wire

FILE: bench/lru_tag_cache_16_slot_top_tb.sv
// Testbench for lru_tag_cache_16_slot_top: directed and random lookups, fills and
// invalidates checked beat by beat against a local LRU mirror. Depends on lruc_pkg.
`default_nettype none

module lru_tag_cache_16_slot_top_tb;

    localparam logic [lruc_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int CALM_TAIL = 60;
    localparam int RANDOM_ITEMS = 630;

    typedef struct packed {
        logic [lruc_pkg::MODE_W-1:0] op;
        lruc_pkg::key_t              k;
    } cache_req_t;

    typedef struct packed {
        logic                            hit;
        logic [lruc_pkg::SLOT_OUT_W-1:0] slot;
    } cache_resp_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [lruc_pkg::MODE_W-1:0]     mode = '0;
    lruc_pkg::key_t                  key = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            hit;
    logic [lruc_pkg::SLOT_OUT_W-1:0] slot;

    cache_req_t      pending_reqs[$];
    cache_resp_t     predicted_results[$];
    lruc_pkg::key_t  tag_mirror[lruc_pkg::SLOTS];
    lruc_pkg::slot_t recency_mirror[lruc_pkg::SLOTS];
    lruc_pkg::key_t  key_pool[24];
    int              err_count = 0;
    int              src_gap = 0;
    int              sink_stall = 0;

    lru_tag_cache_16_slot_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .slot      (slot)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_mirror();
        for (int p = 0; p < lruc_pkg::SLOTS; p++)
        begin
            tag_mirror[p] = '0;
            recency_mirror[p] = lruc_pkg::slot_t'(p);
        end
    endfunction

    function automatic void promote_slot(input lruc_pkg::slot_t s);
        int where;
        where = 0;
        for (int p = 0; p < lruc_pkg::SLOTS; p++)
            if (recency_mirror[p] == s)
                where = p;
        for (int p = where; p > 0; p--)
            recency_mirror[p] = recency_mirror[p-1];
        recency_mirror[0] = s;
    endfunction

    function automatic cache_resp_t lru_predict(input logic [lruc_pkg::MODE_W-1:0] op,
                                                input lruc_pkg::key_t k);
        cache_resp_t     r;
        lruc_pkg::slot_t victim;
        int              found;
        victim = recency_mirror[lruc_pkg::SLOTS-1];
        found = -1;
        r.hit = 1'b0;
        r.slot = '0;
        case (op)
            lruc_pkg::MODE_LOOKUP:
            begin
                if (k != '0)
                    for (int s = 0; s < lruc_pkg::SLOTS; s++)
                        if (found < 0 && tag_mirror[s] == k)
                            found = s;
                if (found >= 0)
                begin
                    r.hit = 1'b1;
                    r.slot = lruc_pkg::SLOT_OUT_W'(found);
                    promote_slot(lruc_pkg::slot_t'(found));
                end
                else
                begin
                    r.slot = lruc_pkg::SLOT_OUT_W'(victim);
                end
            end
            lruc_pkg::MODE_FILL:
            begin
                tag_mirror[victim] = k;
                promote_slot(victim);
                r.slot = lruc_pkg::SLOT_OUT_W'(victim);
            end
            lruc_pkg::MODE_INVAL:
            begin
                clear_mirror();
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void queue_req(input logic [lruc_pkg::MODE_W-1:0] op,
                                      input lruc_pkg::key_t k);
        cache_req_t r;
        r.op = op;
        r.k = k;
        pending_reqs.push_back(r);
    endfunction

    // driver
    always @(posedge clk)
    begin
        logic       calm;
        cache_req_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            calm = pending_reqs.size() < CALM_TAIL;
            if (in_valid && in_ready)
                predicted_results.push_back(lru_predict(mode, key));
            if (!(in_valid && !in_ready))
            begin
                if (src_gap > 0)
                begin
                    src_gap = src_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 && !calm && $urandom_range(0, 5) == 0)
                begin
                    src_gap = $urandom_range(0, 7);
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    r = pending_reqs.pop_front();
                    mode <= r.op;
                    key <= r.k;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        logic        calm;
        cache_resp_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            calm = pending_reqs.size() < CALM_TAIL;
            if (out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result beat with nothing expected: hit %0d slot %0d", hit, slot);
                    err_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        err_count++;
                    end
                    if (slot !== want.slot)
                    begin
                        $error("slot: expected %0d, got %0d", want.slot, slot);
                        err_count++;
                    end
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall = sink_stall - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                sink_stall = $urandom_range(0, 7);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int             n;
        int             pick;
        lruc_pkg::key_t k;
        clear_mirror();

        // directed: zero key, duplicate tags, spare mode, invalidate
        queue_req(lruc_pkg::MODE_LOOKUP, 16'h0000);
        queue_req(lruc_pkg::MODE_LOOKUP, 16'hFFFF);
        queue_req(lruc_pkg::MODE_FILL,   16'hFFFF);
        queue_req(lruc_pkg::MODE_FILL,   16'h0001);
        queue_req(lruc_pkg::MODE_FILL,   16'h0000);
        queue_req(lruc_pkg::MODE_LOOKUP, 16'h0000);
        queue_req(lruc_pkg::MODE_LOOKUP, 16'hFFFF);
        queue_req(lruc_pkg::MODE_FILL,   16'h0001);
        queue_req(lruc_pkg::MODE_LOOKUP, 16'h0001);
        queue_req(lruc_pkg::MODE_FILL,   16'hAAAA);
        queue_req(lruc_pkg::MODE_FILL,   16'h5555);
        queue_req(MODE_SPARE,            16'hA5A5);
        queue_req(lruc_pkg::MODE_LOOKUP, 16'h5555);
        queue_req(lruc_pkg::MODE_LOOKUP, 16'hAAAA);
        queue_req(lruc_pkg::MODE_INVAL,  16'h5A5A);
        queue_req(lruc_pkg::MODE_LOOKUP, 16'hFFFF);
        queue_req(lruc_pkg::MODE_FILL,   16'h8000);
        queue_req(lruc_pkg::MODE_FILL,   16'h4000);
        queue_req(lruc_pkg::MODE_FILL,   16'h0002);
        queue_req(lruc_pkg::MODE_LOOKUP, 16'h8000);
        queue_req(lruc_pkg::MODE_LOOKUP, 16'h0002);
        queue_req(MODE_SPARE,            16'hFFFF);
        queue_req(lruc_pkg::MODE_INVAL,  16'hFFFF);
        queue_req(lruc_pkg::MODE_LOOKUP, 16'h0001);

        foreach (key_pool[i])
            key_pool[i] = lruc_pkg::key_t'($urandom);

        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            k = key_pool[$urandom_range(0, 23)];
            if (pick < 45)
                queue_req(lruc_pkg::MODE_LOOKUP, k);
            else if (pick < 75)
                queue_req(lruc_pkg::MODE_FILL, k);
            else if (pick < 80)
                queue_req(lruc_pkg::MODE_LOOKUP, lruc_pkg::key_t'($urandom));
            else if (pick < 84)
                queue_req(lruc_pkg::MODE_FILL, lruc_pkg::key_t'($urandom));
            else if (pick < 87)
                queue_req(lruc_pkg::MODE_LOOKUP, '0);
            else if (pick < 89)
                queue_req(lruc_pkg::MODE_FILL, '0);
            else if (pick == 90)
                queue_req(lruc_pkg::MODE_INVAL, lruc_pkg::key_t'($urandom));
            else if (pick < 94)
                queue_req(MODE_SPARE, lruc_pkg::key_t'($urandom));
            else
                queue_req(lruc_pkg::MODE_LOOKUP, k);
            if (pick < 91 || pick > 93)
                n++;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (err_count == 0)
            $display("lru_tag_cache_16_slot_top_tb: clean");
        else
            $display("lru_tag_cache_16_slot_top_tb: errors");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("lru_tag_cache_16_slot_top_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
hdl/lruc_pkg.sv
hdl/lruc_tag_store.sv
hdl/lruc_order_store.sv
hdl/lru_tag_cache_16_slot_top.sv
bench/lru_tag_cache_16_slot_top_tb.sv
